// ===== design/otme_pkg.sv =====
// shared types and constants for the object table match engine
`timescale 1ns / 1ps

package otme_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int SLOT_W      = 8;
    localparam int CMP_W       = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;
    localparam int GRP         = 16;
    localparam int NGRP        = (TABLE_DEPTH + GRP - 1) / GRP;

    localparam logic [7:0] CLASS_MASK_RST  = 8'd240;
    localparam logic [7:0] CLASS_VALUE_RST = 8'd16;

    typedef enum logic [2:0] {
        OP_CLEAR      = 3'd0,
        OP_ADD        = 3'd1,
        OP_REMOVE     = 3'd2,
        OP_FIND_POS   = 3'd3,
        OP_FIND_CLASS = 3'd4
    } t_opcode;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_FULL      = 2'd1,
        STS_NOT_FOUND = 2'd2,
        STS_BAD_INDEX = 2'd3
    } t_status;

    typedef enum logic {
        CFG_CLASS_MASK  = 1'b0,
        CFG_CLASS_VALUE = 1'b1
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MATCH,
        ST_TREE,
        ST_LOAD,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [6:0] x;
        logic [6:0] y;
        logic [7:0] kind;
        logic [7:0] payload;
    } t_entry;

    typedef struct packed {
        logic              go;
        logic              do_clear;
        logic              do_add;
        logic              do_remove;
        logic              do_pos;
        logic              do_cls;
        t_entry            item;
        logic [7:0]        mask;
        logic [7:0]        value;
        logic [CNT_W-1:0]  count;
        logic [SLOT_W-1:0] slot;
    } t_cell_cmd;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] idx;
        t_entry           ent;
    } t_hit;

endpackage

// ===== design/otme_cell.sv =====
// one table cell: stored entry, valid flag, local match and shift from its upper neighbor
`timescale 1ns / 1ps

module otme_cell (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  otme_pkg::t_cell_cmd      i_cmd,
    input  logic [otme_pkg::IDX_W-1:0] i_index,
    input  otme_pkg::t_entry         i_next,
    output otme_pkg::t_entry         o_entry,
    output logic                     o_match
);
    import otme_pkg::*;

    logic             r_valid;
    logic             n_valid;
    logic             r_match;
    logic             n_match;
    t_entry           r_entry;
    t_entry           n_entry;
    logic [CMP_W-1:0] w_idx;
    logic [CMP_W-1:0] w_idx_p1;
    logic [CMP_W-1:0] w_slot;
    logic [CMP_W-1:0] w_cnt;

    assign w_idx    = CMP_W'(i_index);
    assign w_idx_p1 = w_idx + CMP_W'(1);
    assign w_slot   = CMP_W'(i_cmd.slot);
    assign w_cnt    = CMP_W'(i_cmd.count);

    always_comb begin
        n_valid = r_valid;
        n_entry = r_entry;
        n_match = r_match;
        if (i_cmd.go) begin
            n_match = 1'b0;
        end
        if (i_cmd.do_clear) begin
            n_valid = 1'b0;
        end
        if (i_cmd.do_add && (w_idx == w_cnt)) begin
            n_entry = i_cmd.item;
            n_valid = 1'b1;
        end
        if (i_cmd.do_remove) begin
            if ((w_idx >= w_slot) && (w_idx_p1 < w_cnt)) begin
                n_entry = i_next;
            end
            if (w_idx_p1 == w_cnt) begin
                n_valid = 1'b0;
            end
        end
        if (i_cmd.do_pos) begin
            n_match = r_valid && (r_entry.x == i_cmd.item.x)
                      && (r_entry.y == i_cmd.item.y);
        end
        if (i_cmd.do_cls) begin
            n_match = r_valid && ((r_entry.kind & i_cmd.mask) == i_cmd.value)
                      && (r_entry.payload == i_cmd.item.payload);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_match <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_match <= n_match;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_match = r_match;

endmodule

// ===== design/otme_select.sv =====
// two-level registered first-hit selection over the cell row
`timescale 1ns / 1ps

module otme_select (
    input  logic                                    i_clk,
    input  logic [otme_pkg::TABLE_DEPTH-1:0]        i_match,
    input  otme_pkg::t_entry [otme_pkg::TABLE_DEPTH-1:0] i_entry,
    output otme_pkg::t_hit                          o_hit
);
    import otme_pkg::*;

    logic   [NGRP*GRP-1:0] w_flag;
    t_entry [NGRP*GRP-1:0] w_ent;
    t_hit   [NGRP-1:0]     r_grp;
    t_hit   [NGRP-1:0]     n_grp;
    t_hit                  r_hit;
    t_hit                  n_hit;

    // pad the row to whole groups
    always_comb begin
        w_flag = '0;
        w_ent  = '0;
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            w_flag[k] = i_match[k];
            w_ent[k]  = i_entry[k];
        end
    end

    // first hit inside each group
    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            n_grp[g] = '0;
            for (int j = GRP - 1; j >= 0; j--) begin
                if (w_flag[g*GRP+j]) begin
                    n_grp[g].hit = 1'b1;
                    n_grp[g].idx = IDX_W'(g*GRP + j);
                    n_grp[g].ent = w_ent[g*GRP+j];
                end
            end
        end
    end

    // first group with a hit
    always_comb begin
        n_hit = '0;
        for (int g = NGRP - 1; g >= 0; g--) begin
            if (r_grp[g].hit) begin
                n_hit = r_grp[g];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp <= n_grp;
        r_hit <= n_hit;
    end

    assign o_hit = r_hit;

endmodule

// ===== design/object_table_match_engine_core.sv =====
// top level of the object table match engine: cell row, selection tree and sequencer
`timescale 1ns / 1ps
//
// Ordered table of up to 256 entries (x, y, kind, payload) held in a row of cells.
// Input channel: i_in_valid / o_in_stall with one operation per request: clear,
// add, remove (later entries shift down one cell), find by position, find by
// class and data. Output channel: o_out_valid / i_out_stall, one result per request
// carrying status, matching entry and the entry count after the operation.
// Configuration: i_cfg_we writes class_mask (index 0) or class_value (index 1).
// Sequence: the table changes at the accept edge, where the cells also register
// their match flags; a two-level registered priority tree over the cells follows,
// and then the result registers are loaded and o_out_valid is raised.
// Throughput: one request at a time; o_in_stall stays high from accept until the
// result has been taken.
// While the receiver stalls, the result register holds and no request is taken.
// Reset (synchronous, active low) empties the table, sets class_mask to 240 and
// class_value to 16, and leaves the block idle.
//
module object_table_match_engine_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [2:0] i_opcode,
    input  logic [6:0] i_pos_x,
    input  logic [6:0] i_pos_y,
    input  logic [7:0] i_kind,
    input  logic [7:0] i_payload,
    input  logic [7:0] i_slot,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_status,
    output logic [7:0] o_hit_index,
    output logic [6:0] o_hit_x,
    output logic [6:0] o_hit_y,
    output logic [7:0] o_hit_kind,
    output logic [7:0] o_hit_payload,
    output logic [8:0] o_fill,
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_data
);
    import otme_pkg::*;

    t_state                    r_state;
    t_state                    n_state;
    logic [7:0]                r_mask;
    logic [7:0]                r_value;
    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          n_count;
    logic                      r_lookup;
    logic                      n_lookup;
    t_status                   r_mstat;
    t_status                   n_mstat;
    t_status                   r_status;
    t_status                   n_status;
    logic [IDX_W-1:0]          r_hit_idx;
    logic [IDX_W-1:0]          n_hit_idx;
    t_entry                    r_hit_ent;
    t_entry                    n_hit_ent;
    logic                      w_accept;
    logic                      w_full;
    logic                      w_slot_ok;
    t_cell_cmd                 w_cmd;
    t_entry [TABLE_DEPTH-1:0]  w_entry;
    t_entry [TABLE_DEPTH-1:0]  w_next;
    logic   [TABLE_DEPTH-1:0]  w_match;
    t_hit                      w_hit;

    assign w_accept  = i_in_valid && !o_in_stall;
    assign w_full    = (r_count == CNT_W'(TABLE_DEPTH));
    assign w_slot_ok = (CMP_W'(i_slot) < CMP_W'(r_count));

    // request decode
    always_comb begin
        w_cmd              = '0;
        w_cmd.go           = w_accept;
        w_cmd.item.x       = i_pos_x;
        w_cmd.item.y       = i_pos_y;
        w_cmd.item.kind    = i_kind;
        w_cmd.item.payload = i_payload;
        w_cmd.mask         = r_mask;
        w_cmd.value        = r_value;
        w_cmd.count        = r_count;
        w_cmd.slot         = i_slot;
        n_count            = r_count;
        n_mstat            = STS_OK;
        n_lookup           = 1'b0;
        case (t_opcode'(i_opcode))
            OP_CLEAR: begin
                w_cmd.do_clear = w_accept;
                n_count        = '0;
            end
            OP_ADD: begin
                if (w_full) begin
                    n_mstat = STS_FULL;
                end else begin
                    w_cmd.do_add = w_accept;
                    n_count      = r_count + CNT_W'(1);
                end
            end
            OP_REMOVE: begin
                if (!w_slot_ok) begin
                    n_mstat = STS_BAD_INDEX;
                end else begin
                    w_cmd.do_remove = w_accept;
                    n_count         = r_count - CNT_W'(1);
                end
            end
            OP_FIND_POS: begin
                w_cmd.do_pos = w_accept;
                n_lookup     = 1'b1;
            end
            OP_FIND_CLASS: begin
                w_cmd.do_cls = w_accept;
                n_lookup     = 1'b1;
            end
            default: begin
                n_mstat = STS_OK;
            end
        endcase
    end

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
            if (gi == TABLE_DEPTH - 1) begin : g_last
                assign w_next[gi] = '0;
            end else begin : g_mid
                assign w_next[gi] = w_entry[gi+1];
            end
            otme_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_cmd   (w_cmd),
                .i_index (IDX_W'(gi)),
                .i_next  (w_next[gi]),
                .o_entry (w_entry[gi]),
                .o_match (w_match[gi])
            );
        end
    endgenerate

    otme_select u_select (
        .i_clk   (i_clk),
        .i_match (w_match),
        .i_entry (w_entry),
        .o_hit   (w_hit)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (w_accept) n_state = ST_MATCH;
            ST_MATCH: n_state = ST_TREE;
            ST_TREE:  n_state = ST_LOAD;
            ST_LOAD:  n_state = ST_OUT;
            ST_OUT:   if (!i_out_stall) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        o_in_stall  = (r_state != ST_IDLE);
        o_out_valid = (r_state == ST_OUT);
    end

    // result selection
    always_comb begin
        n_status  = r_mstat;
        n_hit_idx = '0;
        n_hit_ent = '0;
        if (r_lookup) begin
            if (w_hit.hit) begin
                n_status  = STS_OK;
                n_hit_idx = w_hit.idx;
                n_hit_ent = w_hit.ent;
            end else begin
                n_status = STS_NOT_FOUND;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_mask  <= CLASS_MASK_RST;
            r_value <= CLASS_VALUE_RST;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_count <= n_count;
            end
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_index))
                    CFG_CLASS_MASK:  r_mask  <= i_cfg_data;
                    CFG_CLASS_VALUE: r_value <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_lookup <= n_lookup;
            r_mstat  <= n_mstat;
        end
        if (r_state == ST_LOAD) begin
            r_status  <= n_status;
            r_hit_idx <= n_hit_idx;
            r_hit_ent <= n_hit_ent;
        end
    end

    assign o_status      = r_status;
    assign o_hit_index   = 8'(r_hit_idx);
    assign o_hit_x       = r_hit_ent.x;
    assign o_hit_y       = r_hit_ent.y;
    assign o_hit_kind    = r_hit_ent.kind;
    assign o_hit_payload = r_hit_ent.payload;
    assign o_fill        = 9'(r_count);

endmodule

// ===== design/otme_checker.sv =====
// port-level checks for the object table match engine, bound to the top level
`timescale 1ns / 1ps

module otme_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [1:0] o_status,
    input logic [7:0] o_hit_index,
    input logic [8:0] o_fill
);
    import otme_pkg::*;

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // no request taken while a result waits
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("request accepted while result pending");

    // an accepted request leads to a result
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |-> ##4 o_out_valid)
        else $error("result not ready four cycles after request");

    // entry count bounded by table size
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_fill <= 9'(TABLE_DEPTH))
        else $error("fill beyond table depth");

    // a miss reports index zero
    a_miss_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == STS_NOT_FOUND) |-> (o_hit_index == 8'd0))
        else $error("miss with nonzero index");

endmodule

bind object_table_match_engine_core otme_checker u_otme_checker (.*);

// ===== verif/tb_top.sv =====
// self-checking testbench for the object table match engine core
`timescale 1ns / 1ps

module tb_top;
    import otme_pkg::*;

    typedef struct {
        logic [2:0] opcode;
        logic [6:0] pos_x;
        logic [6:0] pos_y;
        logic [7:0] kind;
        logic [7:0] payload;
        logic [7:0] slot;
    } t_table_req;

    typedef struct packed {
        t_status    status;
        logic [7:0] hit_index;
        logic [6:0] hit_x;
        logic [6:0] hit_y;
        logic [7:0] hit_kind;
        logic [7:0] hit_payload;
        logic [8:0] fill;
    } t_table_result;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    logic [2:0] i_opcode = '0;
    logic [6:0] i_pos_x = '0;
    logic [6:0] i_pos_y = '0;
    logic [7:0] i_kind = '0;
    logic [7:0] i_payload = '0;
    logic [7:0] i_slot = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic [1:0] o_status;
    logic [7:0] o_hit_index;
    logic [6:0] o_hit_x;
    logic [6:0] o_hit_y;
    logic [7:0] o_hit_kind;
    logic [7:0] o_hit_payload;
    logic [8:0] o_fill;
    logic       i_cfg_we = 1'b0;
    logic       i_cfg_index = 1'b0;
    logic [7:0] i_cfg_data = '0;

    object_table_match_engine_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_opcode      (i_opcode),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_kind        (i_kind),
        .i_payload     (i_payload),
        .i_slot        (i_slot),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_hit_index   (o_hit_index),
        .o_hit_x       (o_hit_x),
        .o_hit_y       (o_hit_y),
        .o_hit_kind    (o_hit_kind),
        .o_hit_payload (o_hit_payload),
        .o_fill        (o_fill),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // table model and configuration copy
    t_entry     model_table [TABLE_DEPTH];
    int         model_count = 0;
    logic [7:0] cls_mask = CLASS_MASK_RST;
    logic [7:0] cls_value = CLASS_VALUE_RST;

    t_table_req    pending_ops[$];
    t_table_result expected_results[$];
    t_table_req    cur_req;
    t_table_result oldest;
    int            ops_queued = 0;
    int            ops_accepted = 0;
    int            mismatches = 0;
    int            gen_fill = 0;
    int            burst_left = 1;
    int            gap_left = 0;
    int            stall_mode = 0;
    int            stall_span = 0;

    initial begin
        foreach (model_table[k]) model_table[k] = '0;
    end

    function automatic t_table_result apply_table_op(t_table_req r);
        t_table_result res;
        int            i;
        bit            found;
        res = '0;
        res.status = STS_OK;
        found = 1'b0;
        case (r.opcode)
            OP_CLEAR: begin
                foreach (model_table[k]) model_table[k] = '0;
                model_count = 0;
            end
            OP_ADD: begin
                if (model_count >= TABLE_DEPTH) begin
                    res.status = STS_FULL;
                end else begin
                    model_table[model_count] = {r.pos_x, r.pos_y, r.kind, r.payload};
                    model_count++;
                end
            end
            OP_REMOVE: begin
                if (int'(r.slot) >= model_count) begin
                    res.status = STS_BAD_INDEX;
                end else begin
                    for (i = int'(r.slot); i + 1 < model_count; i++)
                        model_table[i] = model_table[i + 1];
                    model_table[model_count - 1] = '0;
                    model_count--;
                end
            end
            OP_FIND_POS, OP_FIND_CLASS: begin
                for (i = 0; i < model_count && !found; i++) begin
                    if (r.opcode == OP_FIND_POS)
                        found = model_table[i].x == r.pos_x && model_table[i].y == r.pos_y;
                    else
                        found = (model_table[i].kind & cls_mask) == cls_value &&
                                model_table[i].payload == r.payload;
                    if (found) begin
                        res.hit_index   = 8'(i);
                        res.hit_x       = model_table[i].x;
                        res.hit_y       = model_table[i].y;
                        res.hit_kind    = model_table[i].kind;
                        res.hit_payload = model_table[i].payload;
                    end
                end
                if (!found) res.status = STS_NOT_FOUND;
            end
            default: ;
        endcase
        res.fill = 9'(model_count);
        return res;
    endfunction

    function automatic void queue_request(t_table_req r);
        pending_ops.push_back(r);
        ops_queued++;
        case (r.opcode)
            OP_CLEAR:  gen_fill = 0;
            OP_ADD:    if (gen_fill < TABLE_DEPTH) gen_fill++;
            OP_REMOVE: if (int'(r.slot) < gen_fill) gen_fill--;
            default: ;
        endcase
    endfunction

    function automatic void queue_op(logic [2:0] op, logic [6:0] x, logic [6:0] y,
                                     logic [7:0] kind, logic [7:0] payload, logic [7:0] slot);
        t_table_req r;
        r = '{op, x, y, kind, payload, slot};
        queue_request(r);
    endfunction

    // narrow pools make lookups hit often
    function automatic t_table_req rand_req();
        t_table_req r;
        int         pick;
        pick = $urandom_range(0, 99);
        r.pos_x   = 7'($urandom);
        r.pos_y   = 7'($urandom);
        r.kind    = 8'($urandom);
        r.payload = 8'($urandom);
        r.slot    = 8'($urandom);
        if (pick < 2)       r.opcode = OP_CLEAR;
        else if (pick < 34) r.opcode = OP_ADD;
        else if (pick < 56) r.opcode = OP_REMOVE;
        else if (pick < 75) r.opcode = OP_FIND_POS;
        else if (pick < 94) r.opcode = OP_FIND_CLASS;
        else                r.opcode = 3'($urandom_range(OP_FIND_CLASS + 1, 7));
        if ($urandom_range(0, 3) != 0) begin
            r.pos_x   = 7'($urandom_range(0, 3));
            r.pos_y   = 7'($urandom_range(0, 3));
            r.payload = 8'($urandom_range(0, 7));
        end
        if ($urandom_range(0, 1) != 0)
            r.kind = (cls_value & cls_mask) | (8'($urandom) & ~cls_mask);
        if (r.opcode == OP_REMOVE && gen_fill > 0 && $urandom_range(0, 4) != 0)
            r.slot = 8'($urandom_range(0, gen_fill - 1));
        return r;
    endfunction

    function automatic void queue_random(int n);
        for (int k = 0; k < n; k++) queue_request(rand_req());
    endfunction

    task automatic wait_drained();
        while (ops_accepted != ops_queued || expected_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_cfg(t_cfg_reg idx, logic [7:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_CLASS_MASK) cls_mask = val;
        else cls_value = val;
    endtask

    task automatic check_field(string name, logic [8:0] want_v, logic [8:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
            mismatches++;
        end
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                expected_results.push_back(apply_table_op(cur_req));
                ops_accepted++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pending_ops.size() == 0) begin
                    i_in_valid <= 1'b0;
                end else begin
                    cur_req = pending_ops.pop_front();
                    i_opcode   <= cur_req.opcode;
                    i_pos_x    <= cur_req.pos_x;
                    i_pos_y    <= cur_req.pos_y;
                    i_kind     <= cur_req.kind;
                    i_payload  <= cur_req.payload;
                    i_slot     <= cur_req.slot;
                    i_in_valid <= 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                                 : $urandom_range(1, 12);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
                    end
                end
            end
        end
    end

    // result stall pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (stall_span == 0) begin
                stall_mode = $urandom_range(0, 2);
                stall_span = $urandom_range(20, 200);
            end else begin
                stall_span--;
            end
            case (stall_mode)
                0:       i_out_stall <= 1'b0;
                1:       i_out_stall <= ($urandom_range(0, 2) == 0);
                default: i_out_stall <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $display("%0t ns: result with none expected, expected nothing, got status %0d fill %0d",
                         $time, o_status, o_fill);
                mismatches++;
            end else begin
                oldest = expected_results.pop_front();
                check_field("status", 9'(oldest.status), 9'(o_status));
                check_field("hit_index", 9'(oldest.hit_index), 9'(o_hit_index));
                check_field("hit_x", 9'(oldest.hit_x), 9'(o_hit_x));
                check_field("hit_y", 9'(oldest.hit_y), 9'(o_hit_y));
                check_field("hit_kind", 9'(oldest.hit_kind), 9'(o_hit_kind));
                check_field("hit_payload", 9'(oldest.hit_payload), 9'(o_hit_payload));
                check_field("fill", oldest.fill, o_fill);
            end
        end
    end

    initial begin
        t_table_req r;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table, reserved opcodes, basic hits and removal shifts
        queue_op(OP_FIND_POS, 7'd0, 7'd0, 8'd0, 8'd0, 8'd0);
        queue_op(OP_FIND_CLASS, 7'd0, 7'd0, 8'd0, 8'd0, 8'd0);
        queue_op(OP_REMOVE, 7'd0, 7'd0, 8'd0, 8'd0, 8'd0);
        queue_op(OP_REMOVE, 7'd0, 7'd0, 8'd0, 8'd0, 8'd255);
        for (int k = OP_FIND_CLASS + 1; k < 8; k++)
            queue_op(3'(k), 7'd127, 7'd127, 8'hff, 8'hff, 8'hff);
        queue_op(OP_ADD, 7'd0, 7'd0, 8'h00, 8'h00, 8'd0);
        queue_op(OP_ADD, 7'd127, 7'd127, 8'hff, 8'hff, 8'd0);
        queue_op(OP_ADD, 7'd5, 7'd9, 8'h1a, 8'h33, 8'd0);
        queue_op(OP_ADD, 7'd5, 7'd9, 8'h2b, 8'h44, 8'd0);
        queue_op(OP_FIND_POS, 7'd5, 7'd9, 8'd0, 8'd0, 8'd0);
        queue_op(OP_FIND_POS, 7'd127, 7'd127, 8'd0, 8'd0, 8'd0);
        queue_op(OP_FIND_POS, 7'd1, 7'd1, 8'd0, 8'd0, 8'd0);
        queue_op(OP_FIND_CLASS, 7'd0, 7'd0, 8'd0, 8'h33, 8'd0);
        queue_op(OP_FIND_CLASS, 7'd0, 7'd0, 8'd0, 8'h44, 8'd0);
        queue_op(OP_FIND_CLASS, 7'd0, 7'd0, 8'd0, 8'h00, 8'd0);
        queue_op(OP_REMOVE, 7'd0, 7'd0, 8'd0, 8'd0, 8'd3);
        queue_op(OP_REMOVE, 7'd0, 7'd0, 8'd0, 8'd0, 8'd0);
        queue_op(OP_FIND_POS, 7'd127, 7'd127, 8'd0, 8'd0, 8'd0);
        queue_op(OP_REMOVE, 7'd0, 7'd0, 8'd0, 8'd0, 8'd2);
        queue_op(OP_CLEAR, 7'd0, 7'd0, 8'd0, 8'd0, 8'd0);
        queue_op(OP_FIND_POS, 7'd0, 7'd0, 8'd0, 8'd0, 8'd0);
        wait_drained();

        // fill to capacity, then work on a full table
        write_cfg(CFG_CLASS_MASK, 8'hff);
        write_cfg(CFG_CLASS_VALUE, 8'h00);
        queue_op(OP_CLEAR, 7'd0, 7'd0, 8'd0, 8'd0, 8'd0);
        for (int k = 0; k < TABLE_DEPTH + 3; k++) begin
            r = rand_req();
            r.opcode = OP_ADD;
            queue_request(r);
        end
        for (int k = 0; k < 6; k++) begin
            r = rand_req();
            r.opcode = (k % 2 != 0) ? OP_FIND_POS : OP_FIND_CLASS;
            queue_request(r);
        end
        queue_op(OP_REMOVE, 7'd0, 7'd0, 8'd0, 8'd0, 8'd255);
        queue_op(OP_ADD, 7'd127, 7'd0, 8'h00, 8'hff, 8'd0);
        queue_op(OP_REMOVE, 7'd0, 7'd0, 8'd0, 8'd0, 8'd0);
        queue_op(OP_ADD, 7'd0, 7'd127, 8'hff, 8'h00, 8'd0);
        queue_op(OP_REMOVE, 7'd0, 7'd0, 8'd0, 8'd0, 8'd128);
        queue_random(150);
        wait_drained();

        write_cfg(CFG_CLASS_MASK, 8'h00);
        queue_random(200);
        wait_drained();
        queue_random(200);
        wait_drained();

        write_cfg(CFG_CLASS_VALUE, 8'hff);
        queue_random(150);
        wait_drained();

        write_cfg(CFG_CLASS_MASK, CLASS_MASK_RST);
        write_cfg(CFG_CLASS_VALUE, CLASS_VALUE_RST);
        queue_random(300);
        wait_drained();

        write_cfg(CFG_CLASS_MASK, 8'($urandom));
        write_cfg(CFG_CLASS_VALUE, 8'($urandom));
        queue_random(350);
        wait_drained();

        repeat (10) @(posedge i_clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
